FILE: rtl/core/vta_pkg.sv
package vta_pkg;

    // Field and register widths.
    localparam int COORD_BITS     = 24;
    localparam int WEIGHT_BITS    = 16;
    localparam int ANGLE_BITS     = 12;
    localparam int CORDIC_STAGES  = 24;
    localparam int CFG_INDEX_BITS = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_WEIGHT = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_WEIGHT = CFG_INDEX_BITS'(1);

    // Weighted components: |dy| * x_weight is unsigned, dx * y_weight is signed.
    localparam int A_BITS    = COORD_BITS + WEIGHT_BITS;
    localparam int B_BITS    = COORD_BITS + WEIGHT_BITS + 1;
    // The weighted pair is moved up so that its top sits at bit 58.
    localparam int PRE_SHIFT = 58 - (COORD_BITS + WEIGHT_BITS);
    // CORDIC datapath: magnitude stays below 2^59 including the gain.
    localparam int CW        = 61;

    // Angle accumulator, radians in Q24.
    localparam int ZW        = 28;
    localparam longint Z_HALF_PI = 26353589;

    // Radians (Q24) to tenths of a degree: z * 5729578 / (10000 * 2^24).
    localparam longint SCALE_NUM      = 5729578;
    localparam int     SCALE_NUM_BITS = 23;
    localparam int     PW             = ZW + SCALE_NUM_BITS;
    localparam int     DEN_SHIFT      = 24;
    localparam int     DEN_DIV        = 10000;
    localparam longint ROUND_HALF     = longint'(DEN_DIV / 2) * (longint'(1) << DEN_SHIFT);
    localparam int     TW             = PW - DEN_SHIFT + 1;
    localparam int     RECIP_SHIFT    = 38;
    localparam longint RECIP          = (longint'(1) << RECIP_SHIFT) / DEN_DIV;
    localparam int     RECIP_BITS     = 25;
    localparam int     QW             = 15;
    localparam int     HALF_BITS      = 11;

    localparam int ANGLE_HALF_TURN = 1800;
    localparam int ANGLE_QUARTER   = 900;

    // Where the base angle comes from.
    typedef enum logic [1:0] {
        BASE_CORDIC,
        BASE_ZERO,
        BASE_RIGHT
    } t_base;

    // Control word that travels with each request down the pipeline.
    typedef struct packed {
        logic  valid;
        logic  zero_vec;
        logic  lower;
        t_base base;
    } t_ctl;

    // atan(2^-i) rounded to nearest in Q24.
    function automatic logic signed [ZW-1:0] atan_q24(input int unsigned idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:       v = ZW'(13176795);
            1:       v = ZW'(7778716);
            2:       v = ZW'(4110060);
            3:       v = ZW'(2086331);
            4:       v = ZW'(1047214);
            5:       v = ZW'(524117);
            6:       v = ZW'(262123);
            7:       v = ZW'(131069);
            8:       v = ZW'(65536);
            9:       v = ZW'(32768);
            10:      v = ZW'(16384);
            11:      v = ZW'(8192);
            12:      v = ZW'(4096);
            13:      v = ZW'(2048);
            14:      v = ZW'(1024);
            15:      v = ZW'(512);
            16:      v = ZW'(256);
            17:      v = ZW'(128);
            18:      v = ZW'(64);
            19:      v = ZW'(32);
            20:      v = ZW'(16);
            21:      v = ZW'(8);
            22:      v = ZW'(4);
            23:      v = ZW'(2);
            24:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/vta_prep.sv
module vta_prep (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  logic signed [vta_pkg::COORD_BITS-1:0]       i_delta_x,
    input  logic signed [vta_pkg::COORD_BITS-1:0]       i_delta_y,
    input  logic        [vta_pkg::WEIGHT_BITS-1:0]      i_x_weight,
    input  logic        [vta_pkg::WEIGHT_BITS-1:0]      i_y_weight,
    output vta_pkg::t_ctl                               o_ctl,
    output logic signed [vta_pkg::CW-1:0]               o_x,
    output logic signed [vta_pkg::CW-1:0]               o_y,
    output logic signed [vta_pkg::ZW-1:0]               o_z
);

    localparam int C  = vta_pkg::COORD_BITS;
    localparam int AB = vta_pkg::A_BITS;
    localparam int BB = vta_pkg::B_BITS;
    localparam int CW = vta_pkg::CW;
    localparam int ZW = vta_pkg::ZW;

    // Fold into the upper half plane.
    logic                 dx_pos;
    logic                 dy_pos;
    logic                 lower;
    logic [C-1:0]         ady;
    logic signed [C:0]    ext_dx;
    logic signed [C:0]    fdx;
    vta_pkg::t_ctl        n1_ctl;

    always_comb begin
        dx_pos = !i_delta_x[C-1] && (i_delta_x != '0);
        dy_pos = !i_delta_y[C-1] && (i_delta_y != '0);
        lower  = dx_pos ? dy_pos : !i_delta_y[C-1];
        ady    = i_delta_y[C-1] ? (~i_delta_y + 1'b1) : i_delta_y;
        ext_dx = {i_delta_x[C-1], i_delta_x};
        fdx    = lower ? -ext_dx : ext_dx;

        n1_ctl.valid    = i_valid;
        n1_ctl.zero_vec = (i_delta_x == '0) && (i_delta_y == '0);
        n1_ctl.lower    = lower;
        if (i_y_weight == '0) begin
            n1_ctl.base = vta_pkg::BASE_ZERO;
        end else if (i_x_weight == '0) begin
            n1_ctl.base = vta_pkg::BASE_RIGHT;
        end else begin
            n1_ctl.base = vta_pkg::BASE_CORDIC;
        end
    end

    vta_pkg::t_ctl        r1_ctl;
    logic [C-1:0]         r1_ady;
    logic signed [C:0]    r1_fdx;
    vta_pkg::t_ctl        r2_ctl;
    logic [AB-1:0]        r2_a;
    logic signed [BB-1:0] r2_b;
    vta_pkg::t_ctl        r3_ctl;
    logic signed [CW-1:0] r3_x;
    logic signed [CW-1:0] r3_y;
    logic signed [ZW-1:0] r3_z;

    // Start vector: rotate by a quarter turn when the x side is negative.
    logic signed [BB-1:0] neg_b;
    logic signed [CW-1:0] ext_a;
    logic signed [CW-1:0] ext_b;
    logic signed [CW-1:0] ext_nb;

    always_comb begin
        neg_b  = -r2_b;
        ext_a  = CW'(r2_a);
        ext_b  = CW'(r2_b);
        ext_nb = CW'(neg_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= n1_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ady <= ady;
            r1_fdx <= fdx;
            r2_a   <= AB'(r1_ady) * AB'(i_x_weight);
            r2_b   <= BB'(r1_fdx * $signed({1'b0, i_y_weight}));
            if (r2_b[BB-1]) begin
                r3_x <= ext_a << vta_pkg::PRE_SHIFT;
                r3_y <= ext_nb << vta_pkg::PRE_SHIFT;
                r3_z <= ZW'(vta_pkg::Z_HALF_PI);
            end else begin
                r3_x <= ext_b << vta_pkg::PRE_SHIFT;
                r3_y <= ext_a << vta_pkg::PRE_SHIFT;
                r3_z <= '0;
            end
        end
    end

    assign o_ctl = r3_ctl;
    assign o_x   = r3_x;
    assign o_y   = r3_y;
    assign o_z   = r3_z;

endmodule

FILE: rtl/core/vta_cordic.sv
module vta_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  vta_pkg::t_ctl                     i_ctl,
    input  logic signed [vta_pkg::CW-1:0]     i_x,
    input  logic signed [vta_pkg::CW-1:0]     i_y,
    input  logic signed [vta_pkg::ZW-1:0]     i_z,
    output vta_pkg::t_ctl                     o_ctl,
    output logic signed [vta_pkg::ZW-1:0]     o_z
);

    localparam int N  = vta_pkg::CORDIC_STAGES;
    localparam int CW = vta_pkg::CW;
    localparam int ZW = vta_pkg::ZW;

    // Tap g holds the vector before iteration g; tap N is the final one.
    vta_pkg::t_ctl        w_ctl [N+1];
    logic signed [CW-1:0] w_x   [N+1];
    logic signed [CW-1:0] w_y   [N+1];
    logic signed [ZW-1:0] w_z   [N+1];

    assign w_ctl[0] = i_ctl;
    assign w_x[0]   = i_x;
    assign w_y[0]   = i_y;
    assign w_z[0]   = i_z;

    for (genvar g = 0; g < N; g++) begin : g_stage
        vta_pkg::t_ctl        r_ctl;
        logic signed [CW-1:0] r_x;
        logic signed [CW-1:0] r_y;
        logic signed [ZW-1:0] r_z;
        logic signed [CW-1:0] sh_x;
        logic signed [CW-1:0] sh_y;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [ZW-1:0] n_z;

        // Drive y toward zero; the shifts floor like the arithmetic shift.
        always_comb begin
            sh_x = w_x[g] >>> g;
            sh_y = w_y[g] >>> g;
            if (!w_y[g][CW-1]) begin
                n_x = w_x[g] + sh_y;
                n_y = w_y[g] - sh_x;
                n_z = w_z[g] + vta_pkg::atan_q24(g);
            end else begin
                n_x = w_x[g] - sh_y;
                n_y = w_y[g] + sh_x;
                n_z = w_z[g] - vta_pkg::atan_q24(g);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (i_en) begin
                r_ctl <= w_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
        end

        assign w_ctl[g+1] = r_ctl;
        assign w_x[g+1]   = r_x;
        assign w_y[g+1]   = r_y;
        assign w_z[g+1]   = r_z;
    end

    assign o_ctl = w_ctl[N];
    assign o_z   = w_z[N];

endmodule

FILE: rtl/core/vta_scale.sv
module vta_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  vta_pkg::t_ctl                        i_ctl,
    input  logic signed [vta_pkg::ZW-1:0]        i_z,
    output vta_pkg::t_ctl                        o_ctl,
    output logic [vta_pkg::HALF_BITS-1:0]        o_tenths
);

    localparam int PW = vta_pkg::PW;
    localparam int TW = vta_pkg::TW;
    localparam int QW = vta_pkg::QW;
    localparam int MW = TW + vta_pkg::RECIP_BITS;
    localparam int HB = vta_pkg::HALF_BITS;

    localparam logic signed [PW-1:0] SCALE = PW'(vta_pkg::SCALE_NUM);

    vta_pkg::t_ctl        r1_ctl;
    logic signed [PW-1:0] r1_p;
    vta_pkg::t_ctl        r2_ctl;
    logic                 r2_neg;
    logic [TW-1:0]        r2_t;
    vta_pkg::t_ctl        r3_ctl;
    logic                 r3_neg;
    logic [TW-1:0]        r3_t;
    logic [QW-1:0]        r3_qe;
    vta_pkg::t_ctl        r4_ctl;
    logic [HB-1:0]        r4_q;

    logic [PW:0]          sum;
    logic [MW-1:0]        prod;
    logic [TW-1:0]        back;
    logic [TW-1:0]        rem;
    logic [QW-1:0]        q;
    logic [HB-1:0]        n4_q;

    // Quotient by 10000: reciprocal estimate, then one correction step,
    // since the estimate is never high and at most one low.
    always_comb begin
        sum  = {1'b0, r1_p} + (PW + 1)'(vta_pkg::ROUND_HALF);
        prod = MW'(r2_t) * MW'(vta_pkg::RECIP);
        back = TW'(r3_qe) * TW'(vta_pkg::DEN_DIV);
        rem  = r3_t - back;
        q    = (rem >= TW'(vta_pkg::DEN_DIV)) ? (r3_qe + 1'b1) : r3_qe;
        if (r3_neg) begin
            n4_q = '0;
        end else if (q > QW'(vta_pkg::ANGLE_HALF_TURN)) begin
            n4_q = HB'(vta_pkg::ANGLE_HALF_TURN);
        end else begin
            n4_q = HB'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p   <= PW'(i_z) * SCALE;
            r2_neg <= r1_p[PW-1];
            r2_t   <= TW'(sum >> vta_pkg::DEN_SHIFT);
            r3_neg <= r2_neg;
            r3_t   <= r2_t;
            r3_qe  <= QW'(prod >> vta_pkg::RECIP_SHIFT);
            r4_q   <= n4_q;
        end
    end

    assign o_ctl    = r4_ctl;
    assign o_tenths = r4_q;

endmodule

FILE: rtl/core/vector_angle_tenths_degree.sv
// Vector direction in tenths of a degree. Each request carries a signed
// vector (delta_x, delta_y) and yields one result: the direction measured
// clockwise from the positive x axis, 0 to 3600 tenths, with zero_vector
// set (and angle 0) when both components are zero. Before the angle is
// taken, |delta_y| is weighted by x_weight and delta_x by y_weight; a zero
// y_weight gives a base angle of 0 and a zero x_weight a base angle of 900,
// with 1800 added in the clockwise half turn. The block is a fully
// unrolled pipeline: three stages fold, weight and set up the vector, one
// registered stage per CORDIC iteration (24) follows, then four stages
// scale radians to rounded tenths and the output register holds the
// result. A new request is taken every cycle; the whole pipeline holds only
// while a valid result sits at the output under stall. Weights are written
// through the configuration port, which is always ready, and should only
// change while no request is in flight.
module vector_angle_tenths_degree (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Request channel.
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [vta_pkg::COORD_BITS-1:0]   i_delta_x,
    input  logic signed [vta_pkg::COORD_BITS-1:0]   i_delta_y,
    // Result channel.
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic [vta_pkg::ANGLE_BITS-1:0]          o_angle_tenths,
    output logic                                    o_zero_vector,
    // Configuration write channel.
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [vta_pkg::CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  logic [vta_pkg::WEIGHT_BITS-1:0]         i_cfg_data
);

    localparam int AW = vta_pkg::ANGLE_BITS;

    // Weight registers. A write to an index outside the list is accepted
    // and dropped.
    logic [vta_pkg::WEIGHT_BITS-1:0] r_x_weight;
    logic [vta_pkg::WEIGHT_BITS-1:0] r_y_weight;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_weight <= vta_pkg::WEIGHT_BITS'(1);
            r_y_weight <= vta_pkg::WEIGHT_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == vta_pkg::CFG_X_WEIGHT) begin
                r_x_weight <= i_cfg_data;
            end
            if (i_cfg_index == vta_pkg::CFG_Y_WEIGHT) begin
                r_y_weight <= i_cfg_data;
            end
        end
    end

    // Every stage moves together. The pipeline only freezes when the
    // output register holds a result that the receiver is stalling, so
    // nothing is dropped or duplicated and bubbles never block input.
    logic          r_out_valid;
    logic          w_en;

    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // Fold, weight and build the start vector.
    vta_pkg::t_ctl                     w_prep_ctl;
    logic signed [vta_pkg::CW-1:0]     w_prep_x;
    logic signed [vta_pkg::CW-1:0]     w_prep_y;
    logic signed [vta_pkg::ZW-1:0]     w_prep_z;

    vta_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_in_valid),
        .i_delta_x  (i_delta_x),
        .i_delta_y  (i_delta_y),
        .i_x_weight (r_x_weight),
        .i_y_weight (r_y_weight),
        .o_ctl      (w_prep_ctl),
        .o_x        (w_prep_x),
        .o_y        (w_prep_y),
        .o_z        (w_prep_z)
    );

    // One registered stage per CORDIC iteration.
    vta_pkg::t_ctl                     w_cor_ctl;
    logic signed [vta_pkg::ZW-1:0]     w_cor_z;

    vta_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_prep_ctl),
        .i_x     (w_prep_x),
        .i_y     (w_prep_y),
        .i_z     (w_prep_z),
        .o_ctl   (w_cor_ctl),
        .o_z     (w_cor_z)
    );

    // Radians to rounded tenths, clamped to a half turn.
    vta_pkg::t_ctl                       w_sc_ctl;
    logic [vta_pkg::HALF_BITS-1:0]       w_sc_tenths;

    vta_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_cor_ctl),
        .i_z      (w_cor_z),
        .o_ctl    (w_sc_ctl),
        .o_tenths (w_sc_tenths)
    );

    // Output register: choose the base angle, then unfold the half turn.
    logic [AW-1:0] base;
    logic [AW-1:0] n_angle;
    logic [AW-1:0] r_angle;
    logic          r_zero;

    always_comb begin
        unique case (w_sc_ctl.base)
            vta_pkg::BASE_ZERO:  base = '0;
            vta_pkg::BASE_RIGHT: base = AW'(vta_pkg::ANGLE_QUARTER);
            default:             base = AW'(w_sc_tenths);
        endcase
        if (w_sc_ctl.zero_vec) begin
            n_angle = '0;
        end else if (w_sc_ctl.lower) begin
            n_angle = base + AW'(vta_pkg::ANGLE_HALF_TURN);
        end else begin
            n_angle = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_sc_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_angle <= n_angle;
            r_zero  <= w_sc_ctl.zero_vec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_angle_tenths = r_angle;
    assign o_zero_vector  = r_zero;

endmodule

FILE: rtl/core/vta_checker.sv
module vta_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    o_in_stall,
    input logic                                    o_out_valid,
    input logic                                    i_out_stall,
    input logic [vta_pkg::ANGLE_BITS-1:0]          o_angle_tenths,
    input logic                                    o_zero_vector
);

    localparam int AW = vta_pkg::ANGLE_BITS;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A zero vector always reports angle zero.
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_vector |-> o_angle_tenths == '0)
        else $error("zero vector with nonzero angle");

    // The angle never exceeds one full turn.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_angle_tenths <= AW'(2 * vta_pkg::ANGLE_HALF_TURN))
        else $error("angle beyond a full turn");

    // Requests are only held back by a stalled result.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while output is free");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_angle_tenths)
            && $stable(o_zero_vector))
        else $error("stalled result changed");

endmodule

bind vector_angle_tenths_degree vta_checker u_vta_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_angle_tenths (o_angle_tenths),
    .o_zero_vector  (o_zero_vector)
);

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vta_pkg::*;

    // One request: the vector whose direction is asked for.
    typedef struct {
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
    } t_vector;

    // One predicted result, together with the vector it came from for messages.
    typedef struct {
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
        logic [ANGLE_BITS-1:0]        angle;
        logic                         zero;
    } t_direction;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // The two register indexes that map to nothing; writes there must be ignored.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_A = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_B = CFG_INDEX_BITS'(3);

    // Fixed-point constants of the angle computation.
    localparam int     PRE_UP       = 58 - (COORD_BITS + WEIGHT_BITS);
    localparam longint HALF_PI_Q24  = 26353589;
    localparam longint TENTHS_NUM   = 5729578;
    localparam longint TENTHS_DEN   = longint'(10000) << 24;
    localparam longint ROUND_BIAS   = TENTHS_DEN / 2;
    localparam longint QUARTER_TURN = 900;
    localparam longint HALF_TURN    = 1800;

    // atan(2^-k) in radians with 24 fractional bits, rounded to nearest.
    localparam longint ATAN_Q24 [32] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    // Edge vectors: the zero vector, the four axes at unit and full length, the
    // corners of the range, the unit diagonals, vectors one step off the x axis
    // at full length, which round to 0, 1800 or 3600, and two such off the y axis.
    localparam int EDGE_COUNT = 23;
    localparam logic signed [COORD_BITS-1:0] EDGE_DX [EDGE_COUNT] = '{
        0, 1, -1, 0, 0, COORD_MAX, COORD_MIN, 0, 0, COORD_MAX, COORD_MIN, COORD_MAX,
        COORD_MIN, 1, 1, -1, -1, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1, -1
    };
    localparam logic signed [COORD_BITS-1:0] EDGE_DY [EDGE_COUNT] = '{
        0, 0, 0, 1, -1, 0, 0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
        COORD_MAX, 1, -1, 1, -1, 1, -1, 1, -1, COORD_MAX, COORD_MIN
    };
    localparam logic signed [COORD_BITS-1:0] EXTREMES [5] = '{
        COORD_MIN, COORD_MAX, -1, 0, 1
    };

    // Weight settings of the first phases: the extremes, a zero on either
    // side and on both, lopsided pairs and a small pair. Later phases draw weights at random.
    localparam int FIXED_PHASES = 7;
    localparam logic [WEIGHT_BITS-1:0] FIXED_XW [FIXED_PHASES] = '{
        16'hFFFF, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'd1, 16'd2
    };
    localparam logic [WEIGHT_BITS-1:0] FIXED_YW [FIXED_PHASES] = '{
        16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd1, 16'hFFFF, 16'd3
    };
    localparam int TOTAL_PHASES     = 14;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int TAIL_CYCLES      = 40;
    localparam int PRINT_CAP        = 40;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    logic signed [COORD_BITS-1:0]  i_delta_x   = '0;
    logic signed [COORD_BITS-1:0]  i_delta_y   = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [ANGLE_BITS-1:0]         o_angle_tenths;
    logic                          o_zero_vector;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index = '0;
    logic [WEIGHT_BITS-1:0]        i_cfg_data  = '0;

    // Our own copy of the two weight registers, as the block should hold them.
    logic [WEIGHT_BITS-1:0] x_weight_cfg = 16'd1;
    logic [WEIGHT_BITS-1:0] y_weight_cfg = 16'd1;

    t_vector    pending_vectors[$];
    t_direction expected_dirs[$];
    int         error_count = 0;

    // Sender state.
    t_vector next_vector;
    int      send_gap   = 0;
    bit      send_burst = 1'b0;

    // Receiver state. The stimulus process raises receiver_hold_go once; the
    // monitor then stalls its side for a long stretch, counting on its own.
    t_direction result_want;
    int         recv_wait          = 0;
    bit         recv_burst         = 1'b0;
    bit         receiver_hold_go   = 1'b0;
    bit         receiver_hold_done = 1'b0;
    bit         long_hold_active   = 1'b0;
    int         hold_count         = 0;

    always #6 i_clk = ~i_clk;

    vector_angle_tenths_degree i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_delta_x      (i_delta_x),
        .i_delta_y      (i_delta_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_angle_tenths (o_angle_tenths),
        .o_zero_vector  (o_zero_vector),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Angle of the weighted pair (a >= 0) in tenths of a degree, 0..1800.
    // Vectors left of the y axis are first turned by a quarter so that the
    // vectoring iterations start from a positive x.
    function automatic longint cordic_half_turn(longint a, longint b);
        longint x, y, z, p, q, step_x, step_y;
        int     k;
        if (b < 0) begin
            x = a << PRE_UP;
            y = (-b) << PRE_UP;
            z = HALF_PI_Q24;
        end else begin
            x = b << PRE_UP;
            y = a << PRE_UP;
            z = 0;
        end
        for (k = 0; k < CORDIC_STAGES; k++) begin
            step_x = y >>> k;
            step_y = x >>> k;
            if (y >= 0) begin
                x = x + step_x;
                y = y - step_y;
                z = z + ATAN_Q24[k];
            end else begin
                x = x - step_x;
                y = y + step_y;
                z = z - ATAN_Q24[k];
            end
        end
        // Radians to tenths of a degree, rounded half away from zero.
        p = z * TENTHS_NUM;
        if (p >= 0) begin
            q = (p + ROUND_BIAS) / TENTHS_DEN;
        end else begin
            q = -((-p + ROUND_BIAS) / TENTHS_DEN);
        end
        if (q < 0) q = 0;
        if (q > HALF_TURN) q = HALF_TURN;
        return q;
    endfunction

    // Expected result for one request under the current weights.
    function automatic t_direction predict_direction(logic signed [COORD_BITS-1:0] vx,
                                                     logic signed [COORD_BITS-1:0] vy);
        t_direction r;
        longint     dx, dy, ang;
        bit         lower_half;
        r.dx    = vx;
        r.dy    = vy;
        r.angle = '0;
        r.zero  = 1'b0;
        dx      = vx;
        dy      = vy;
        if (dx == 0 && dy == 0) begin
            r.zero = 1'b1;
            return r;
        end
        // The half from 180 to 360 degrees clockwise; a vector straight up
        // belongs to it, a vector straight down does not.
        lower_half = (dx > 0) ? (dy > 0) : (dy >= 0);
        if (dy < 0) dy = -dy;
        if (lower_half) dx = -dx;
        if (y_weight_cfg == 0) begin
            ang = 0;
        end else if (x_weight_cfg == 0) begin
            ang = QUARTER_TURN;
        end else begin
            ang = cordic_half_turn(dy * longint'(x_weight_cfg), dx * longint'(y_weight_cfg));
        end
        if (lower_half) ang = ang + HALF_TURN;
        r.angle = ang[ANGLE_BITS-1:0];
        return r;
    endfunction

    // A random vector. Four in ten are fully random; the rest aim at the axes, the
    // extremes, the diagonals, tiny vectors around zero, directions just off
    // the x axis, and a spread of magnitudes.
    function automatic t_vector random_vector();
        t_vector v;
        int      sel;
        sel  = $urandom_range(0, 9);
        v.dx = COORD_BITS'($urandom());
        v.dy = COORD_BITS'($urandom());
        case (sel)
            4: begin
                v.dx = COORD_BITS'(int'($urandom_range(0, 8)) - 4);
                v.dy = COORD_BITS'(int'($urandom_range(0, 8)) - 4);
            end
            5: begin
                if ($urandom_range(0, 1) == 0) v.dx = '0;
                else v.dy = '0;
            end
            6: begin
                v.dx = EXTREMES[$urandom_range(0, 4)];
                v.dy = EXTREMES[$urandom_range(0, 4)];
            end
            7: begin
                v.dy = COORD_BITS'(int'($urandom_range(0, 6)) - 3);
            end
            8: begin
                v.dy = ($urandom_range(0, 1) == 0) ? v.dx : -v.dx;
                v.dy = v.dy + COORD_BITS'(int'($urandom_range(0, 2)) - 1);
            end
            9: begin
                v.dx = v.dx >>> $urandom_range(0, COORD_BITS - 1);
                v.dy = v.dy >>> $urandom_range(0, COORD_BITS - 1);
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // One register write; the copy of the registers follows at the edge where
    // the write is taken. Indexes that map to nothing leave the copy alone.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [WEIGHT_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_X_WEIGHT) x_weight_cfg = data;
        else if (idx == CFG_Y_WEIGHT) y_weight_cfg = data;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // The block is idle once every queued request went in and every
    // predicted result came out. Checked on the falling edge, away from
    // the edge where the driver and the monitor work.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_vectors.size() != 0 || expected_dirs.size() != 0 || i_in_valid);
    endtask

    task automatic queue_edge_vectors();
        t_vector v;
        for (int k = 0; k < EDGE_COUNT; k++) begin
            v.dx = EDGE_DX[k];
            v.dy = EDGE_DY[k];
            pending_vectors.push_back(v);
        end
    endtask

    // Driver: presents queued requests and predicts the result of each one
    // the block takes. After each request it draws a random gap of idle
    // cycles, except in bursts, which switch on and off at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_dirs.push_back(predict_direction(i_delta_x, i_delta_y));
            end
            // A new request may go out only when none is held under stall.
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_vectors.size() > 0) begin
                    next_vector = pending_vectors.pop_front();
                    i_in_valid <= 1'b1;
                    i_delta_x  <= next_vector.dx;
                    i_delta_y  <= next_vector.dy;
                    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 7);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result taken against the oldest prediction and
    // drives the stall of the result side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_dirs.size() == 0) begin
                    report_error($sformatf("result with nothing pending: angle %0d zero %0b",
                                           o_angle_tenths, o_zero_vector));
                end else begin
                    result_want = expected_dirs.pop_front();
                    if (o_angle_tenths !== result_want.angle) begin
                        report_error($sformatf("dx %0d dy %0d: angle %0d, predicted %0d",
                                               result_want.dx, result_want.dy,
                                               o_angle_tenths, result_want.angle));
                    end
                    if (o_zero_vector !== result_want.zero) begin
                        report_error($sformatf("dx %0d dy %0d: zero_vector %0b, predicted %0b",
                                               result_want.dx, result_want.dy,
                                               o_zero_vector, result_want.zero));
                    end
                end
            end
            if (long_hold_active) begin
                // The long hold lets the pipeline fill up so that the block
                // has to stall the request side.
                hold_count++;
                if (hold_count >= LONG_HOLD_CYCLES) begin
                    long_hold_active = 1'b0;
                    i_out_stall <= 1'b0;
                end else begin
                    i_out_stall <= 1'b1;
                end
            end else if (receiver_hold_go && !receiver_hold_done) begin
                receiver_hold_done = 1'b1;
                long_hold_active   = 1'b1;
                hold_count         = 0;
                i_out_stall <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 7);
                i_out_stall <= (recv_wait != 0);
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_out_stall <= (recv_wait != 0);
            end
        end
    end

    // Watchdog: ends the run when nothing at all is taken for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stimulus: reset, the edge vectors under the reset weights, then phases
    // that each set the weights while the block is idle, queue requests and
    // wait until every result is back. The wait between phases doubles as
    // the pause of the sender.
    initial begin : stimulus
        int                     phase;
        int                     count;
        logic [WEIGHT_BITS-1:0] xw, yw;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_register(CFG_X_WEIGHT, 16'd1);
        write_register(CFG_Y_WEIGHT, 16'd1);
        queue_edge_vectors();
        wait_idle();

        for (phase = 0; phase < TOTAL_PHASES; phase++) begin
            if (phase < FIXED_PHASES) begin
                xw = FIXED_XW[phase];
                yw = FIXED_YW[phase];
            end else begin
                // Small weights now and then, to stress coarse ratios.
                xw = ($urandom_range(0, 3) == 0) ? WEIGHT_BITS'($urandom_range(1, 16))
                                                 : WEIGHT_BITS'($urandom_range(1, 65535));
                yw = ($urandom_range(0, 3) == 0) ? WEIGHT_BITS'($urandom_range(1, 16))
                                                 : WEIGHT_BITS'($urandom_range(1, 65535));
            end
            write_register(CFG_X_WEIGHT, xw);
            write_register(CFG_Y_WEIGHT, yw);
            // Writes to the unmapped indexes must leave both weights alone.
            if (phase == 0 || $urandom_range(0, 2) == 0) begin
                write_register(CFG_UNMAPPED_A, WEIGHT_BITS'($urandom()));
                write_register(CFG_UNMAPPED_B, WEIGHT_BITS'($urandom()));
            end
            if (phase == 0) receiver_hold_go = 1'b1;
            if (phase < FIXED_PHASES) begin
                queue_edge_vectors();
                count = (phase == 0) ? 120 : 55;
            end else begin
                count = 75;
            end
            repeat (count) pending_vectors.push_back(random_vector());
            wait_idle();
        end

        // Keep clocking in case the block gives out results it should not.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_dirs.size() != 0) begin
            report_error($sformatf("%0d results never came", expected_dirs.size()));
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
